// ----- design/twds_pkg.sv -----
// ----------------------------------------------------------------------------
// Timing wheel package
// Shared sizes, operation codes and sequencer states of the tick wheel.
// ----------------------------------------------------------------------------
package twds_pkg;

   localparam int NUM_TASKS  = 32;
   localparam int WHEEL_SIZE = 16;
   localparam int TASK_W     = $clog2(NUM_TASKS);
   localparam int LINK_W     = TASK_W + 1;
   localparam int SPOKE_W    = $clog2(WHEEL_SIZE);
   localparam int CNT_W      = $clog2(NUM_TASKS + 1);

   localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLINK,
      ST_WALK,
      ST_LINK,
      ST_TICK,
      ST_EMIT
   } state_type;

endpackage

// ----- design/tick_wheel_delay_scheduler.sv -----
// ----------------------------------------------------------------------------
// Tick wheel delay scheduler
// Timing wheel of task delays: insert, remove and tick under one sequencer
// that walks a spoke list one entry per cycle through a shared compare.
// ----------------------------------------------------------------------------
// Sequence: remove runs UNLINK; insert runs UNLINK, WALK over the entries
// passed on the spoke, then LINK; tick runs TICK plus an EMIT per expired task
// (each waits for the output register). One transaction at a time: requests
// are stalled until the sequencer is back in IDLE.
// Reset: synchronous, clears state, counter, waiting flags, spoke heads and counts, output valid.
module tick_wheel_delay_scheduler
   import twds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [4:0]          req_task_index,
   input  logic [31:0]         req_delay_ticks,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [4:0]          rsp_ready_task,
   output logic                rsp_last_ready
);

   state_type state_ff, state_in;
   logic [31:0]        tick_ff, tick_in;
   logic [NUM_TASKS-1:0] wait_ff;
   logic [LINK_W-1:0]  head_ff [WHEEL_SIZE];
   logic [CNT_W-1:0]   count_ff [WHEEL_SIZE];
   logic [31:0]        match_mem [NUM_TASKS];
   logic [LINK_W-1:0]  next_mem [NUM_TASKS];
   logic [LINK_W-1:0]  prev_mem [NUM_TASKS];
   logic [SPOKE_W-1:0] spoke_mem [NUM_TASKS];

   logic [1:0]         op_ff;
   logic [TASK_W-1:0]  task_ff;
   logic [31:0]        delay_ff;
   logic [LINK_W-1:0]  cur_ff, before_ff;
   logic               out_valid_ff;
   logic [TASK_W-1:0]  out_task_ff;
   logic               out_last_ff;

   // shared compare: remaining ticks of the current walk entry
   logic [31:0] rem;
   logic        stop_walk;
   logic [31:0] new_match;
   logic [SPOKE_W-1:0] new_spoke;
   logic [SPOKE_W-1:0] tick_spoke;
   logic [LINK_W-1:0]  tick_head;
   logic               head_fires;
   logic [TASK_W-1:0]  cur_idx;

   // unlink port signals
   logic              do_unlink;
   logic [TASK_W-1:0] ul_t;
   logic [LINK_W-1:0] ul_p, ul_n;
   logic [SPOKE_W-1:0] ul_s;

   assign cur_idx    = cur_ff[TASK_W-1:0];
   assign rem        = match_mem[cur_idx] - tick_ff;
   assign stop_walk  = (cur_ff == NIL) || (delay_ff <= rem);
   assign new_match  = tick_ff + delay_ff;
   assign new_spoke  = new_match[SPOKE_W-1:0];
   assign tick_spoke = tick_ff[SPOKE_W-1:0];
   assign tick_head  = head_ff[tick_spoke];
   assign head_fires = (tick_head != NIL) &&
                       (match_mem[tick_head[TASK_W-1:0]] == tick_ff);

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_ready_task = out_task_ff;
   assign rsp_last_ready = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      tick_in  = tick_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (op_type'(req_operation))
                  OP_TICK:   begin
                     state_in = ST_TICK;
                     tick_in  = tick_ff + 32'd1;
                  end
                  OP_INSERT: state_in = ST_UNLINK;
                  OP_REMOVE: state_in = ST_UNLINK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_UNLINK: state_in = (op_ff == OP_INSERT) ? ST_WALK : ST_IDLE;
         ST_WALK:   state_in = stop_walk ? ST_LINK : ST_WALK;
         ST_LINK:   state_in = ST_IDLE;
         ST_TICK:   state_in = (!out_valid_ff || !rsp_stall) ?
                               (head_fires ? ST_EMIT : ST_IDLE) : ST_TICK;
         ST_EMIT:   state_in = ST_TICK;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the counter, the transaction and the walk pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff    <= req_operation;
         task_ff  <= req_task_index[TASK_W-1:0];
         delay_ff <= req_delay_ticks;
      end
      if (state_ff == ST_UNLINK) begin
         // start past the slot itself when it leaves the head of this spoke
         if (do_unlink && ul_p == NIL && ul_s == new_spoke) cur_ff <= ul_n;
         else cur_ff <= head_ff[new_spoke];
         before_ff <= NIL;
      end else if (state_ff == ST_WALK && !stop_walk) begin
         before_ff <= cur_ff;
         cur_ff    <= next_mem[cur_idx];
      end
   end

   // unlink one slot; shared by remove, reinsert and expiry
   assign ul_t = (state_ff == ST_EMIT) ? tick_head[TASK_W-1:0] : task_ff;
   assign do_unlink = ((state_ff == ST_UNLINK) && wait_ff[ul_t]) ||
                      (state_ff == ST_EMIT);
   assign ul_p = prev_mem[ul_t];
   assign ul_n = next_mem[ul_t];
   assign ul_s = spoke_mem[ul_t];

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff <= '0;
         for (int i = 0; i < WHEEL_SIZE; i++) begin
            head_ff[i]  <= NIL;
            count_ff[i] <= '0;
         end
      end else if (do_unlink) begin
         wait_ff[ul_t] <= 1'b0;
         if (ul_p == NIL) head_ff[ul_s] <= ul_n;
         count_ff[ul_s] <= count_ff[ul_s] - 1'b1;
      end else if (state_ff == ST_LINK) begin
         wait_ff[task_ff] <= 1'b1;
         if (before_ff == NIL) head_ff[new_spoke] <= {1'b0, task_ff};
         count_ff[new_spoke] <= count_ff[new_spoke] + 1'b1;
      end
   end

   // link memories
   always_ff @(posedge clock) begin
      if (do_unlink) begin
         if (ul_p != NIL) next_mem[ul_p[TASK_W-1:0]] <= ul_n;
         if (ul_n != NIL) prev_mem[ul_n[TASK_W-1:0]] <= ul_p;
      end else if (state_ff == ST_LINK) begin
         match_mem[task_ff] <= new_match;
         spoke_mem[task_ff] <= new_spoke;
         next_mem[task_ff]  <= cur_ff;
         prev_mem[task_ff]  <= before_ff;
         if (before_ff != NIL) next_mem[before_ff[TASK_W-1:0]] <= {1'b0, task_ff};
         if (cur_ff != NIL) prev_mem[cur_idx] <= {1'b0, task_ff};
      end
   end

   // output register: load an expired task, drop it once taken
   logic tick_next_fires;
   assign tick_next_fires = (ul_n != NIL) &&
                            (match_mem[ul_n[TASK_W-1:0]] == tick_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (state_ff == ST_EMIT) begin
         out_task_ff <= ul_t;
         out_last_ff <= !tick_next_fires;
      end
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("accepting while busy");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!out_valid_ff || !rsp_stall))
      else $error("output overwritten");
   a_tick_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_operation == OP_TICK)
      |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("tick not advanced");

endmodule
